### design/rrts_pkg.sv
// Package: shared constants, codes and control types of the task ring scheduler.
`default_nettype none
package rrts_pkg;
  localparam int MAX_TASKS = 16;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int PID_W     = 16;
  localparam int PCNT_W    = PID_W + 1;
  localparam int OP_W      = 3;
  localparam int STAT_W    = 3;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE   = 3'd0,
    OP_KILL_PID = 3'd1,
    OP_KILL_CUR = 3'd2,
    OP_TICK     = 3'd3,
    OP_QUERY    = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_REFUSED   = 3'd2,
    ST_FULL      = 3'd3,
    ST_NO_RUN    = 3'd4
  } stat_t;

  typedef enum logic [1:0] {
    RS_READY  = 2'd0,
    RS_RUN    = 2'd1,
    RS_ZOMBIE = 2'd2
  } run_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_EXEC,
    CS_WSTART,
    CS_WALK,
    CS_RESP
  } ctrl_st_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic walk_init;
    logic walk_step;
    logic finish;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic need_walk;
    logic hit;
    logic last;
    logic out_free;
  } dp_sts_t;
endpackage
`default_nettype wire

### design/rrts_if.sv
// Interfaces: request and result channels of the task ring scheduler.
`default_nettype none
interface rrts_in_if;
  import rrts_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [PID_W-1:0]  target_pid;
  logic              user_mode;
  modport source (output valid, operation, target_pid, user_mode, input ready);
  modport sink   (input valid, operation, target_pid, user_mode, output ready);
endinterface

interface rrts_out_if;
  import rrts_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [PID_W-1:0]  result_pid;
  logic [SLOT_W-1:0] result_slot;
  logic              alive;
  logic              running_is_user;
  modport source (output valid, status, result_pid, result_slot, alive, running_is_user,
                  input ready);
  modport sink   (input valid, status, result_pid, result_slot, alive, running_is_user,
                  output ready);
endinterface
`default_nettype wire

### design/rrts_ctrl.sv
// Controller: sequences accept, decode, ring walk and result transaction.
`default_nettype none
module rrts_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire rrts_pkg::dp_sts_t sts,
  output rrts_pkg::dp_cmd_t     cmd
);
  import rrts_pkg::*;

  ctrl_st_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = CS_EXEC;
        end
      end
      CS_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_walk ? CS_WSTART : CS_RESP;
      end
      CS_WSTART: begin
        cmd.walk_init = 1'b1;
        state_nxt     = CS_WALK;
      end
      CS_WALK: begin
        if (sts.hit || sts.last) begin
          cmd.finish = 1'b1;
          state_nxt  = CS_RESP;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      CS_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### design/rrts_dp.sv
// Datapath: slot table, ring walker, result and output registers.
`default_nettype none
module rrts_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [rrts_pkg::OP_W-1:0]   in_operation,
  input  wire logic [rrts_pkg::PID_W-1:0]  in_target_pid,
  input  wire logic                        in_user_mode,
  input  wire rrts_pkg::dp_cmd_t           cmd,
  output rrts_pkg::dp_sts_t                sts,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [rrts_pkg::STAT_W-1:0]      out_status,
  output logic [rrts_pkg::PID_W-1:0]       out_result_pid,
  output logic [rrts_pkg::SLOT_W-1:0]      out_result_slot,
  output logic                             out_alive,
  output logic                             out_running_is_user
);
  import rrts_pkg::*;

  logic              used_r  [MAX_TASKS];
  logic [PID_W-1:0]  pid_r   [MAX_TASKS];
  run_t              rs_r    [MAX_TASKS];
  logic [SLOT_W-1:0] link_r  [MAX_TASKS];
  logic              user_r  [MAX_TASKS];
  logic [SLOT_W-1:0] tail_r, cur_r;
  logic              cv_r, hz_r;
  logic [PCNT_W-1:0] pcnt_r;

  logic [OP_W-1:0]   op_r;
  logic [PID_W-1:0]  tgt_r;
  logic              um_r;
  logic [SLOT_W-1:0] it_r, start_r, prev_r, cnt_r;

  logic [STAT_W-1:0] res_status_r;
  logic [PID_W-1:0]  res_pid_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic              res_alive_r, res_user_r;

  logic [SLOT_W-1:0] free_slot;
  logic              free_found;
  logic              need_walk_c, hit_c, last_c;
  logic [SLOT_W-1:0] nxt_it;

  always_comb begin
    free_slot  = '0;
    free_found = 1'b0;
    for (int i = MAX_TASKS - 1; i >= 1; i--) begin
      if (!used_r[i]) begin
        free_slot  = SLOT_W'(i);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    case (op_r)
      OP_KILL_PID: need_walk_c = (tgt_r != '0);
      OP_KILL_CUR: need_walk_c = cv_r && (cur_r != '0) && (rs_r[cur_r] != RS_ZOMBIE);
      OP_TICK:     need_walk_c = 1'b1;
      OP_QUERY:    need_walk_c = (tgt_r != '0);
      default:     need_walk_c = 1'b0;
    endcase
  end

  assign nxt_it = link_r[it_r];
  always_comb begin
    if (op_r == OP_TICK) begin
      hit_c = used_r[it_r] && (rs_r[it_r] == RS_READY || rs_r[it_r] == RS_RUN);
    end else begin
      hit_c = used_r[it_r] && (pid_r[it_r] == tgt_r) && (rs_r[it_r] != RS_ZOMBIE);
    end
    last_c = (nxt_it == start_r) || (cnt_r == SLOT_W'(MAX_TASKS - 1));
  end

  assign sts.need_walk = need_walk_c;
  assign sts.hit       = hit_c;
  assign sts.last      = last_c;
  assign sts.out_free  = !out_valid || out_ready;

  // slot table and scheduler state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        used_r[i] <= (i == 0);
        pid_r[i]  <= '0;
        rs_r[i]   <= (i == 0) ? RS_RUN : RS_READY;
        link_r[i] <= '0;
        user_r[i] <= 1'b0;
      end
      tail_r <= '0;
      cur_r  <= '0;
      cv_r   <= 1'b0;
      hz_r   <= 1'b0;
      pcnt_r <= PCNT_W'(1);
    end else if (cmd.exec) begin
      if (op_r == OP_CREATE && free_found && !pcnt_r[PCNT_W-1]) begin
        used_r[free_slot] <= 1'b1;
        pid_r[free_slot]  <= pcnt_r[PID_W-1:0];
        rs_r[free_slot]   <= RS_READY;
        user_r[free_slot] <= um_r;
        link_r[free_slot] <= link_r[tail_r];
        link_r[tail_r]    <= free_slot;
        tail_r            <= free_slot;
        pcnt_r            <= pcnt_r + PCNT_W'(1);
      end else if (op_r == OP_TICK) begin
        if (!cv_r) begin
          cv_r     <= 1'b1;
          cur_r    <= '0;
          rs_r[0]  <= RS_READY;
          hz_r     <= 1'b0;
        end else begin
          hz_r <= (rs_r[cur_r] == RS_ZOMBIE);
          if (rs_r[cur_r] == RS_RUN) begin
            rs_r[cur_r] <= RS_READY;
          end
        end
      end
    end else if (cmd.finish) begin
      if (op_r == OP_TICK) begin
        if (hz_r) begin
          used_r[cur_r] <= 1'b0;
          pid_r[cur_r]  <= '0;
          rs_r[cur_r]   <= RS_READY;
          link_r[cur_r] <= '0;
          user_r[cur_r] <= 1'b0;
          if (!hit_c) begin
            cv_r <= 1'b0;
          end
        end
        if (hit_c) begin
          cur_r       <= it_r;
          rs_r[it_r]  <= RS_RUN;
        end
      end else if ((op_r == OP_KILL_PID || op_r == OP_KILL_CUR) && hit_c &&
                   it_r != '0) begin
        if (cv_r && rs_r[cur_r] == RS_ZOMBIE && cur_r != it_r && link_r[cur_r] == it_r) begin
          link_r[cur_r] <= nxt_it;
        end
        link_r[prev_r] <= nxt_it;
        if (tail_r == it_r) begin
          tail_r <= prev_r;
        end
        if (cv_r && cur_r == it_r) begin
          rs_r[it_r] <= RS_ZOMBIE;
        end else begin
          used_r[it_r] <= 1'b0;
          pid_r[it_r]  <= '0;
          rs_r[it_r]   <= RS_READY;
          link_r[it_r] <= '0;
          user_r[it_r] <= 1'b0;
        end
      end
    end
  end

  // request latch, walker and result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r         <= in_operation;
      tgt_r        <= in_target_pid;
      um_r         <= in_user_mode;
      res_status_r <= ST_OK;
      res_pid_r    <= '0;
      res_slot_r   <= '0;
      res_alive_r  <= 1'b0;
      res_user_r   <= 1'b0;
    end
    if (cmd.exec) begin
      case (op_r)
        OP_CREATE: begin
          if (free_found && !pcnt_r[PCNT_W-1]) begin
            res_pid_r  <= pcnt_r[PID_W-1:0];
            res_slot_r <= free_slot;
          end else begin
            res_status_r <= ST_FULL;
          end
        end
        OP_KILL_PID: begin
          if (tgt_r == '0) begin
            res_status_r <= ST_REFUSED;
          end
        end
        OP_KILL_CUR: begin
          if (!cv_r || cur_r == '0) begin
            res_status_r <= ST_REFUSED;
          end else if (rs_r[cur_r] == RS_ZOMBIE) begin
            res_status_r <= ST_NOT_FOUND;
          end
          tgt_r <= pid_r[cur_r];
        end
        OP_TICK: ;
        OP_QUERY: begin
          if (tgt_r == '0) begin
            res_alive_r <= 1'b1;
          end
        end
        default: res_status_r <= ST_REFUSED;
      endcase
    end
    if (cmd.walk_init) begin
      cnt_r <= '0;
      if (op_r == OP_TICK) begin
        start_r <= link_r[cur_r];
        it_r    <= link_r[cur_r];
        prev_r  <= cur_r;
      end else begin
        start_r <= link_r[tail_r];
        it_r    <= link_r[tail_r];
        prev_r  <= tail_r;
      end
    end
    if (cmd.walk_step) begin
      prev_r <= it_r;
      it_r   <= nxt_it;
      cnt_r  <= cnt_r + SLOT_W'(1);
    end
    if (cmd.finish) begin
      case (op_r)
        OP_TICK: begin
          if (hit_c) begin
            res_pid_r  <= pid_r[it_r];
            res_slot_r <= it_r;
            res_user_r <= user_r[it_r];
          end else begin
            res_status_r <= ST_NO_RUN;
          end
        end
        OP_QUERY: begin
          if (hit_c) begin
            res_alive_r <= 1'b1;
          end else begin
            res_status_r <= ST_NOT_FOUND;
          end
        end
        default: begin
          if (!hit_c) begin
            res_status_r <= ST_NOT_FOUND;
          end else if (it_r == '0) begin
            res_status_r <= ST_REFUSED;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status          <= res_status_r;
      out_result_pid      <= res_pid_r;
      out_result_slot     <= res_slot_r;
      out_alive           <= res_alive_r;
      out_running_is_user <= res_user_r;
    end
  end
endmodule
`default_nettype wire

### design/round_robin_task_ring_scheduler_unit.sv
// Top level: round-robin task ring scheduler, controller plus datapath.
// Create, refused and trivial requests go from accept through execute to the result state without a ring walk.
// Kill, query and tick walk the ring one link per cycle, through the walk start and walk states.
// One transaction is in flight at a time; a stalled output holds the next one in the result state.
// The result register lets the next transaction be accepted while a result waits.
// Reset (synchronous, active low) restores the init task alone in the ring.
`default_nettype none
module round_robin_task_ring_scheduler_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  rrts_in_if.sink   in_chan,
  rrts_out_if.source out_chan
);
  import rrts_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  assign in_chan.ready = in_ready;

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrts_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_operation        (in_chan.operation),
    .in_target_pid       (in_chan.target_pid),
    .in_user_mode        (in_chan.user_mode),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_chan.valid),
    .out_ready           (out_chan.ready),
    .out_status          (out_chan.status),
    .out_result_pid      (out_chan.result_pid),
    .out_result_slot     (out_chan.result_slot),
    .out_alive           (out_chan.alive),
    .out_running_is_user (out_chan.running_is_user)
  );
endmodule
`default_nettype wire

### design/rrts_checker.sv
// Checker: port-level assertions for the task ring scheduler, bound to the top level.
`default_nettype none
module rrts_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [15:0] result_pid,
  input wire logic [3:0]  result_slot,
  input wire logic        alive,
  input wire logic        running_is_user
);
  import rrts_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(result_pid)))
    else $error("stalled result changed");

  a_slot_pid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((result_slot == '0) == (result_pid == '0)))
    else $error("slot and pid disagree");

  a_alive_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && alive) |-> (status == ST_OK && result_pid == '0 && !running_is_user))
    else $error("alive result inconsistent");
endmodule

bind round_robin_task_ring_scheduler_unit rrts_checker u_rrts_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .status          (out_chan.status),
  .result_pid      (out_chan.result_pid),
  .result_slot     (out_chan.result_slot),
  .alive           (out_chan.alive),
  .running_is_user (out_chan.running_is_user)
);
`default_nettype wire
